/* rtl/ps2_mouse_cursor_tracker_unit_defines.svh */
// ============================================================================
// PS/2 cursor tracker assertion macros
// Concurrent assertion shorthands sampled on clk_i, disabled during reset.
// ============================================================================
`ifndef PS2_MOUSE_CURSOR_TRACKER_UNIT_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define PMCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pmct_pkg.sv */
// ============================================================================
// PS/2 cursor tracker package
// Shared constants, register indexes and the packet type.
// ============================================================================
package pmct_pkg;

  localparam int unsigned CoordBitsDef = 12;  // default cursor register width
  localparam int unsigned OutCoordBits = 12;  // width of cursor fields on the bus
  localparam int unsigned InDataBits   = 8;
  localparam int unsigned OutDataBits  = 32;  // 12 + 12 + 1 + 1, padded to bytes
  localparam int unsigned CfgIdxBits   = 2;

  localparam int unsigned MaxXReset = 1023;
  localparam int unsigned MaxYReset = 767;
  localparam int unsigned PosXReset = 820;
  localparam int unsigned PosYReset = 420;

  localparam logic [CfgIdxBits-1:0] CfgMaxX = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgMaxY = 2'd1;

  // decoded movement packet, overflow packets never get here
  typedef struct packed {
    logic       left;
    logic       sign_y;
    logic       sign_x;
    logic [7:0] dy;
    logic [7:0] dx;
  } pkt_t;

endpackage

/* rtl/pmct_packet_asm.sv */
// ============================================================================
// PS/2 packet assembler
// Collects status, X and Y bytes into one registered packet.
// ============================================================================
module pmct_packet_asm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_vld_i,
  input  logic [7:0]    byte_i,
  output logic          byte_rdy_o,
  output logic          pkt_vld_o,
  output pmct_pkg::pkt_t pkt_o,
  input  logic          pkt_rdy_i
);
  import pmct_pkg::*;

  typedef enum logic [2:0] {
    StWaitStatus = 3'b001,
    StWaitDx     = 3'b010,
    StWaitDy     = 3'b100
  } st_e;

  st_e        st_q, st_d;
  logic [7:0] status_q, status_d;
  logic [7:0] dx_q, dx_d;
  logic       pkt_vld_q;
  pkt_t       pkt_q;
  logic       byte_take;
  logic       emit;

  assign byte_rdy_o = !pkt_vld_q || pkt_rdy_i;
  assign byte_take  = byte_vld_i && byte_rdy_o;

  always_comb begin
    st_d     = st_q;
    status_d = status_q;
    dx_d     = dx_q;
    emit     = 1'b0;
    unique case (st_q)
      StWaitDx: begin
        dx_d = byte_i;
        st_d = StWaitDy;
      end
      StWaitDy: begin
        st_d = StWaitStatus;
        emit = (status_q[7:6] == 2'b00);  // drop on X or Y overflow
      end
      default: begin
        // resync: status byte must carry its always-one bit
        if (byte_i[3]) begin
          status_d = byte_i;
          st_d     = StWaitDx;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StWaitStatus;
      status_q  <= '0;
      dx_q      <= '0;
      pkt_vld_q <= 1'b0;
    end else begin
      if (byte_take) begin
        st_q     <= st_d;
        status_q <= status_d;
        dx_q     <= dx_d;
      end
      if (byte_take && emit) begin
        pkt_vld_q <= 1'b1;
      end else if (pkt_rdy_i) begin
        pkt_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_take && emit) begin
      pkt_q.left   <= status_q[0];
      pkt_q.sign_x <= status_q[4];
      pkt_q.sign_y <= status_q[5];
      pkt_q.dx     <= dx_q;
      pkt_q.dy     <= byte_i;
    end
  end

  assign pkt_vld_o = pkt_vld_q;
  assign pkt_o     = pkt_q;

endmodule

/* rtl/pmct_cursor_upd.sv */
// ============================================================================
// PS/2 cursor update
// Applies one packet: add/subtract, clamp, press edge; holds the result.
// ============================================================================
module pmct_cursor_upd #(
  parameter int unsigned COORD_BITS = pmct_pkg::CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [COORD_BITS-1:0] max_x_i,
  input  logic [COORD_BITS-1:0] max_y_i,
  input  logic                  pkt_vld_i,
  input  pmct_pkg::pkt_t        pkt_i,
  output logic                  pkt_rdy_o,
  output logic                  res_vld_o,
  input  logic                  res_rdy_i,
  output logic [COORD_BITS-1:0] pos_x_o,
  output logic [COORD_BITS-1:0] pos_y_o,
  output logic                  left_down_o,
  output logic                  left_press_o
);
  import pmct_pkg::*;

  localparam int unsigned SumBits = COORD_BITS + 2;  // sign + carry headroom

  logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic [COORD_BITS-1:0] pos_x_d, pos_y_d;
  logic                  held_q, press_q, res_vld_q;
  logic [SumBits-1:0]    dx_ext, dy_ext, sum_x, sum_y;
  logic                  pkt_take;

  function automatic logic [COORD_BITS-1:0] clamp(input logic [SumBits-1:0] v,
                                                  input logic [COORD_BITS-1:0] hi);
    logic [COORD_BITS-1:0] r;
    if (v[SumBits-1]) begin
      r = '0;
    end else if (v[SumBits-2:0] > {1'b0, hi}) begin
      r = hi;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign pkt_rdy_o = !res_vld_q || res_rdy_i;
  assign pkt_take  = pkt_vld_i && pkt_rdy_o;

  // 9-bit two's complement movement, sign from the status byte
  assign dx_ext = {{(SumBits-8){pkt_i.sign_x}}, pkt_i.dx};
  assign dy_ext = {{(SumBits-8){pkt_i.sign_y}}, pkt_i.dy};

  assign sum_x = {2'b00, pos_x_q} + dx_ext;
  assign sum_y = {2'b00, pos_y_q} - dy_ext;  // screen Y grows downward

  assign pos_x_d = clamp(sum_x, max_x_i);
  assign pos_y_d = clamp(sum_y, max_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= COORD_BITS'(PosXReset);
      pos_y_q   <= COORD_BITS'(PosYReset);
      held_q    <= 1'b0;
      press_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (pkt_take) begin
        pos_x_q   <= pos_x_d;
        pos_y_q   <= pos_y_d;
        held_q    <= pkt_i.left;
        press_q   <= pkt_i.left && !held_q;
        res_vld_q <= 1'b1;
      end else if (res_rdy_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  assign res_vld_o    = res_vld_q;
  assign pos_x_o      = pos_x_q;
  assign pos_y_o      = pos_y_q;
  assign left_down_o  = held_q;
  assign left_press_o = press_q;

endmodule

/* rtl/ps2_mouse_cursor_tracker_unit.sv */
// PS/2 mouse cursor tracker - usage
// Slave stream: one mouse byte per word in s_axis_tdata[7:0]. Bytes are
// grouped into status / X / Y packets; a status byte without bit 3 set is
// skipped to regain sync. Packets with an overflow bit set are dropped.
// Master stream: one word per good packet with the clamped cursor position,
// left button level and a one-word left-press pulse.
// Config channel: index 0 = max_x, index 1 = max_y, other indexes ignored.
// Write only while idle; cfg_ready_o is always high.
// Path: the third byte of a packet lands in the packet register, which then
// loads the result register that drives m_axis_tvalid; a result register that
// is full and not being drained holds the packet back.
// Throughput: one byte per cycle while s_axis_tready is high; each of the two
// registers takes a new word when it is empty or being drained in the same
// cycle, so the byte path keeps moving while a result waits for the sink.
// A stalled sink holds the result word; once the packet register is also
// full, s_axis_tready drops until the sink takes the word.
// Reset: max 1023 x 767, cursor at (820, 420), button released, sync lost.
// ============================================================================
// PS/2 cursor tracker top level
// Config registers, packet assembler and cursor update with result register.
// ============================================================================
`include "ps2_mouse_cursor_tracker_unit_defines.svh"

module ps2_mouse_cursor_tracker_unit #(
  parameter int unsigned COORD_BITS = pmct_pkg::CoordBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // byte stream in; tdata: [7:0] rx_byte
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pmct_pkg::InDataBits-1:0]     s_axis_tdata,
  // result stream out; tdata: [11:0] cursor_x, [23:12] cursor_y,
  // [24] left_down, [25] left_press, [31:26] zero
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pmct_pkg::OutDataBits-1:0]    m_axis_tdata,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pmct_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [COORD_BITS-1:0]               cfg_data_i
);
  import pmct_pkg::*;

  logic [COORD_BITS-1:0]   max_x_q, max_y_q;
  logic                    pkt_vld, pkt_rdy;
  pkt_t                    pkt;
  logic [COORD_BITS-1:0]   pos_x, pos_y;
  logic                    left_down, left_press;
  logic [OutCoordBits-1:0] cursor_x, cursor_y;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= COORD_BITS'(MaxXReset);
      max_y_q <= COORD_BITS'(MaxYReset);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMaxX: max_x_q <= cfg_data_i;
        CfgMaxY: max_y_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  pmct_packet_asm u_asm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (s_axis_tvalid),
    .byte_i     (s_axis_tdata),
    .byte_rdy_o (s_axis_tready),
    .pkt_vld_o  (pkt_vld),
    .pkt_o      (pkt),
    .pkt_rdy_i  (pkt_rdy)
  );

  pmct_cursor_upd #(
    .COORD_BITS (COORD_BITS)
  ) u_upd (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_x_i      (max_x_q),
    .max_y_i      (max_y_q),
    .pkt_vld_i    (pkt_vld),
    .pkt_i        (pkt),
    .pkt_rdy_o    (pkt_rdy),
    .res_vld_o    (m_axis_tvalid),
    .res_rdy_i    (m_axis_tready),
    .pos_x_o      (pos_x),
    .pos_y_o      (pos_y),
    .left_down_o  (left_down),
    .left_press_o (left_press)
  );

  // bus fields are fixed width; the position register may be narrower or wider
  assign cursor_x = OutCoordBits'(pos_x);
  assign cursor_y = OutCoordBits'(pos_y);

  assign m_axis_tdata = {{(OutDataBits - 2*OutCoordBits - 2){1'b0}},
                         left_press, left_down, cursor_y, cursor_x};

  // a press edge always comes with the button held
  `PMCT_ASSERT_NOW(a_press_held, m_axis_tvalid && left_press, left_down,
                   "left_press without left_down")
  // a new result word only follows a pending packet
  `PMCT_ASSERT_NOW(a_res_from_pkt, $rose(m_axis_tvalid), $past(pkt_vld),
                   "result word without a packet")
  // a packet blocked by the result register is not lost
  `PMCT_ASSERT_NXT(a_pkt_kept, pkt_vld && !pkt_rdy, pkt_vld,
                   "pending packet dropped under stall")

endmodule
